// ===== sv/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants and types for the byte deque with palindrome check.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int CMD_W   = 3;
  localparam int DATA_W  = 8;
  localparam int CNT_W   = 7;
  localparam int STS_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CHECK     = 3'd4;

  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted request
    logic exec;      // apply push/pop, set up the check walk
    logic chk_rd;    // read the current check pair
    logic chk_step;  // compare the pair and advance
    logic out_load;  // capture the result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_chk;
    logic pairs_zero;
    logic mismatch;
  } dp_sts_t;

endpackage

// ===== sv/cdq_ifs.sv =====
// ----------------------------------------------------------------------------
// cdq_ifs
// Request and result channels of the byte deque, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdq_in_if;
  logic                          valid;
  logic                          ready;
  logic [cdq_pkg::CMD_W-1:0]     cmd;
  logic [cdq_pkg::DATA_W-1:0]    value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cdq_out_if;
  logic                          valid;
  logic                          ready;
  logic [cdq_pkg::DATA_W-1:0]    front_value;
  logic [cdq_pkg::DATA_W-1:0]    back_value;
  logic [cdq_pkg::CNT_W-1:0]     count;
  logic                          empty_res;
  logic                          symmetric;
  logic [cdq_pkg::STS_W-1:0]     status;

  modport source (output valid, output front_value, output back_value, output count,
                  output empty_res, output symmetric, output status, input ready);
  modport sink   (input valid, input front_value, input back_value, input count,
                  input empty_res, input symmetric, input status, output ready);
endinterface

// ===== sv/cdq_dp.sv =====
// ----------------------------------------------------------------------------
// cdq_dp
// Datapath: ring buffer memory, head/tail pointers, count, check walker and
// result register.
// ----------------------------------------------------------------------------
module cdq_dp #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdq_pkg::dp_cmd_t            cmd,
  output cdq_pkg::dp_sts_t            sts,
  input  logic [cdq_pkg::CMD_W-1:0]   in_cmd,
  input  logic [cdq_pkg::DATA_W-1:0]  in_value,
  output logic [cdq_pkg::DATA_W-1:0]  out_front_value,
  output logic [cdq_pkg::DATA_W-1:0]  out_back_value,
  output logic [cdq_pkg::CNT_W-1:0]   out_count,
  output logic                        out_empty_res,
  output logic                        out_symmetric,
  output logic [cdq_pkg::STS_W-1:0]   out_status
);

  localparam int PW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];

  logic [cdq_pkg::CMD_W-1:0]  cmd_r;
  logic [cdq_pkg::DATA_W-1:0] val_r;
  logic [PW-1:0]              front_r, front_nxt;
  logic [PW-1:0]              back_r, back_nxt;
  logic [OW-1:0]              occ_r, occ_nxt;
  logic [PW-1:0]              lo_r, lo_nxt;
  logic [PW-1:0]              hi_r, hi_nxt;
  logic [OW-1:0]              pairs_r, pairs_nxt;
  logic                       sym_r, sym_nxt;
  logic [cdq_pkg::STS_W-1:0]  st_r, st_nxt;
  logic [cdq_pkg::DATA_W-1:0] rd0_r, rd1_r;
  logic [PW-1:0]              ra0, ra1, wa;
  logic                       we;
  logic                       full, empty;

  assign full  = (occ_r >= OW'(DEPTH));
  assign empty = (occ_r == '0);

  assign sts.is_chk     = (cmd_r == cdq_pkg::CMD_CHECK);
  assign sts.pairs_zero = (pairs_r == '0);
  assign sts.mismatch   = (rd0_r != rd1_r);

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    occ_nxt   = occ_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    pairs_nxt = pairs_r;
    sym_nxt   = sym_r;
    st_nxt    = st_r;
    we        = 1'b0;
    wa        = back_r;
    if (cmd.exec) begin
      st_nxt    = cdq_pkg::ST_OK;
      sym_nxt   = (cmd_r == cdq_pkg::CMD_CHECK);
      // walk set up from the current ends, only used by a check
      lo_nxt    = front_r;
      hi_nxt    = ring_prev(back_r);
      pairs_nxt = occ_r >> 1;
      case (cmd_r)
        cdq_pkg::CMD_PUSH_HEAD: begin
          if (full) begin
            st_nxt = cdq_pkg::ST_FULL;
          end else begin
            front_nxt = ring_prev(front_r);
            wa        = ring_prev(front_r);
            we        = 1'b1;
            occ_nxt   = occ_r + 1'b1;
          end
        end
        cdq_pkg::CMD_PUSH_TAIL: begin
          if (full) begin
            st_nxt = cdq_pkg::ST_FULL;
          end else begin
            wa       = back_r;
            we       = 1'b1;
            back_nxt = ring_next(back_r);
            occ_nxt  = occ_r + 1'b1;
          end
        end
        cdq_pkg::CMD_POP_HEAD: begin
          if (empty) begin
            st_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            front_nxt = ring_next(front_r);
            occ_nxt   = occ_r - 1'b1;
          end
        end
        cdq_pkg::CMD_POP_TAIL: begin
          if (empty) begin
            st_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            back_nxt = ring_prev(back_r);
            occ_nxt  = occ_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.chk_step) begin
      if (rd0_r != rd1_r) begin
        sym_nxt = 1'b0;
      end else begin
        lo_nxt    = ring_next(lo_r);
        hi_nxt    = ring_prev(hi_r);
        pairs_nxt = pairs_r - 1'b1;
      end
    end
  end

  // read ports: check pair during the walk, head and tail otherwise
  assign ra0 = cmd.chk_rd ? lo_r : front_r;
  assign ra1 = cmd.chk_rd ? hi_r : ring_prev(back_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= val_r;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      occ_r   <= '0;
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      val_r <= in_value;
    end
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    pairs_r <= pairs_nxt;
    sym_r   <= sym_nxt;
    st_r    <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_front_value <= empty ? '0 : rd0_r;
      out_back_value  <= empty ? '0 : rd1_r;
      out_count       <= cdq_pkg::CNT_W'(occ_r);
      out_empty_res   <= empty;
      out_symmetric   <= sym_r;
      out_status      <= st_r;
    end
  end

endmodule

// ===== sv/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Controller: request handshake, command sequencing, check walk and result
// handshake.
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cdq_pkg::dp_cmd_t  cmd,
  input  cdq_pkg::dp_sts_t  sts
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_CHK_RD  = 3'd2;
  localparam logic [2:0] S_CHK_CMP = 3'd3;
  localparam logic [2:0] S_RD      = 3'd4;
  localparam logic [2:0] S_FIN     = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.load     = in_valid && in_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.is_chk ? S_CHK_RD : S_RD;
      end
      S_CHK_RD: begin
        cmd.chk_rd = 1'b1;
        state_nxt  = sts.pairs_zero ? S_RD : S_CHK_CMP;
      end
      S_CHK_CMP: begin
        cmd.chk_step = 1'b1;
        state_nxt    = sts.mismatch ? S_RD : S_CHK_RD;
      end
      S_RD: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for the previous result to drain
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/char_deque_with_palindrome_check.sv =====
// push/pop: the request passes through the exec, read and finish states before the result loads
// check: the walk reads an entry pair, then compares it, pair by pair, until all pairs match or
//   one mismatches; the next request is taken the cycle after the result loads
// a waiting result does not block the next request until that one is done
// synchronous active-low reset clears head, tail, count and handshake state;
//   the entry memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// char_deque_with_palindrome_check
// Bounded byte deque on a ring buffer with head/tail push and pop and a
// palindrome check over the held entries.
// ----------------------------------------------------------------------------
module char_deque_with_palindrome_check #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cdq_in_if.sink     in_ch,
  cdq_out_if.source  out_ch
);

  cdq_pkg::dp_cmd_t dp_cmd;
  cdq_pkg::dp_sts_t dp_sts;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .in_cmd          (in_ch.cmd),
    .in_value        (in_ch.value),
    .out_front_value (out_ch.front_value),
    .out_back_value  (out_ch.back_value),
    .out_count       (out_ch.count),
    .out_empty_res   (out_ch.empty_res),
    .out_symmetric   (out_ch.symmetric),
    .out_status      (out_ch.status)
  );

endmodule

// ===== sv/cdq_chk.sv =====
// ----------------------------------------------------------------------------
// cdq_chk
// Port-level checks on the result channel of the byte deque.
// ----------------------------------------------------------------------------
module cdq_chk #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cdq_pkg::DATA_W-1:0]  front_value,
  input logic [cdq_pkg::DATA_W-1:0]  back_value,
  input logic [cdq_pkg::CNT_W-1:0]   count,
  input logic                        empty_res,
  input logic                        symmetric,
  input logic [cdq_pkg::STS_W-1:0]   status
);

  // empty flag follows the count while the count field is wide enough
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (DEPTH < 128) |-> (empty_res == (count == '0)))
    else $error("empty flag disagrees with count");

  // an empty deque shows zero values
  a_empty_vals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && empty_res |-> (front_value == '0) && (back_value == '0))
    else $error("nonzero value on empty deque");

  // a symmetric answer only comes from a check, which never fails
  a_sym_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && symmetric |-> (status == cdq_pkg::ST_OK))
    else $error("symmetric result with error status");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(front_value) &&
      $stable(back_value) && $stable(count) && $stable(status) && $stable(symmetric))
    else $error("result changed while stalled");

endmodule

bind char_deque_with_palindrome_check cdq_chk #(
  .DEPTH (DEPTH)
) u_cdq_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .front_value (out_ch.front_value),
  .back_value  (out_ch.back_value),
  .count       (out_ch.count),
  .empty_res   (out_ch.empty_res),
  .symmetric   (out_ch.symmetric),
  .status      (out_ch.status)
);

// ===== tb/sv/char_deque_with_palindrome_check_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_deque_with_palindrome_check_tb
// Drives head/tail push and pop requests and palindrome checks into the byte
// deque and checks every result against an in-bench deque model. Starts with
// directed corner cases, then runs mirrored fills, drains, full/empty
// overflows and noise. Both handshake sides throttle, and one long receiver
// stall backs the deque up.
// ----------------------------------------------------------------------------
module char_deque_with_palindrome_check_tb;
  import cdq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int ITEMS_TOTAL = 450;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 200;

  // command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]  count;
    logic              empty_res;
    logic              symmetric;
    logic [STS_W-1:0]  status;
  } deque_result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    int                phase;
    bit                hold;
  } deque_req_t;

  logic clk = 1'b0;
  logic rst_n;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  char_deque_with_palindrome_check uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // deque model state
  logic [DATA_W-1:0] ring_mem [DEPTH];
  int unsigned       head_idx = 0;
  int unsigned       tail_idx = 0;  // one past the tail entry
  int unsigned       held     = 0;

  deque_req_t    req_q [$];
  deque_result_t expected_results [$];

  int  n_items      = 0;
  int  gen_held     = 0;
  int  req_accepted = 0;
  int  res_checked  = 0;
  int  sym_checks   = 0;
  int  sym_true     = 0;
  int  full_rejects = 0;
  int  empty_pops   = 0;
  int  err_cnt      = 0;

  logic in_acc    = 1'b0;
  logic hold_kick = 1'b0;
  int   hold_left = 0;
  int   cur_phase = 0;
  int   tx_idle;
  int   rx_idle;

  always_comb begin
    case (cur_phase)
      0:       begin tx_idle = 37; rx_idle = 45; end
      1:       begin tx_idle = 45; rx_idle = 37; end
      default: begin tx_idle = 0;  rx_idle = 0;  end
    endcase
  end

  function automatic int unsigned ring_back(int unsigned p);
    return (p + DEPTH - 1) % DEPTH;
  endfunction

  function automatic logic [DATA_W-1:0] rand_byte();
    return DATA_W'($urandom_range(255));
  endfunction

  function automatic deque_result_t apply_deque_cmd(logic [CMD_W-1:0] op,
                                                    logic [DATA_W-1:0] data);
    deque_result_t r;
    int unsigned   lo;
    int unsigned   hi;
    r = '0;
    r.status = ST_OK;
    case (op)
      CMD_PUSH_HEAD: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_idx = ring_back(head_idx);
          ring_mem[head_idx] = data;
          held++;
        end
      end
      CMD_PUSH_TAIL: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[tail_idx] = data;
          tail_idx = (tail_idx + 1) % DEPTH;
          held++;
        end
      end
      CMD_POP_HEAD: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          head_idx = (head_idx + 1) % DEPTH;
          held--;
        end
      end
      CMD_POP_TAIL: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          tail_idx = ring_back(tail_idx);
          held--;
        end
      end
      CMD_CHECK: begin
        // compare pairs walking in from both ends
        r.symmetric = 1'b1;
        lo = head_idx;
        hi = ring_back(tail_idx);
        for (int i = 0; i < held / 2; i++) begin
          if (ring_mem[lo] != ring_mem[hi]) r.symmetric = 1'b0;
          lo = (lo + 1) % DEPTH;
          hi = ring_back(hi);
        end
      end
      default: ;
    endcase
    if (held != 0) begin
      r.front_value = ring_mem[head_idx];
      r.back_value  = ring_mem[ring_back(tail_idx)];
    end
    r.count     = held[CNT_W-1:0];
    r.empty_res = (held == 0);
    return r;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // result check first, then the prediction for a newly accepted request
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (!rst_n) begin
      in_acc <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request pending");
          err_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("front_value", int'(exp_r.front_value), int'(out_ch.front_value));
          check_field("back_value",  int'(exp_r.back_value),  int'(out_ch.back_value));
          check_field("count",       int'(exp_r.count),       int'(out_ch.count));
          check_field("empty_res",   int'(exp_r.empty_res),   int'(out_ch.empty_res));
          check_field("symmetric",   int'(exp_r.symmetric),   int'(out_ch.symmetric));
          check_field("status",      int'(exp_r.status),      int'(out_ch.status));
          res_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        exp_r = apply_deque_cmd(in_ch.cmd, in_ch.value);
        expected_results.push_back(exp_r);
        req_accepted++;
        if (in_ch.cmd == CMD_CHECK) begin
          sym_checks++;
          if (exp_r.symmetric) sym_true++;
        end
        if (exp_r.status == ST_FULL)  full_rejects++;
        if (exp_r.status == ST_EMPTY) empty_pops++;
      end
      in_acc <= in_ch.valid && in_ch.ready;
    end
  end

  // request driver
  always @(negedge clk) begin
    deque_req_t req;
    logic       kick;
    kick = 1'b0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_acc) begin
      if (req_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
        req = req_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= req.cmd;
        in_ch.value <= req.value;
        cur_phase   <= req.phase;
        kick = req.hold;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    hold_kick <= kick;
  end

  // long receiver stall, counted on its own
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic add_req(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v);
    deque_req_t req;
    req.cmd   = c;
    req.value = v;
    req.phase = (n_items < ITEMS_TOTAL / 3) ? 0 : (n_items < 2 * ITEMS_TOTAL / 3) ? 1 : 2;
    req.hold  = (n_items == HOLD_AT);
    req_q.push_back(req);
    n_items++;
    case (c)
      CMD_PUSH_HEAD, CMD_PUSH_TAIL: if (gen_held < DEPTH) gen_held++;
      CMD_POP_HEAD, CMD_POP_TAIL:   if (gen_held > 0) gen_held--;
      default: ;
    endcase
  endtask

  task automatic add_rand_pop();
    add_req($urandom_range(1) ? CMD_POP_HEAD : CMD_POP_TAIL, rand_byte());
  endtask

  task automatic add_drain(int extra);
    while (gen_held > 0) add_rand_pop();
    repeat (extra) add_rand_pop();
  endtask

  // symmetric pushes keep a palindrome a palindrome
  task automatic add_mirror_pairs(int k);
    logic [DATA_W-1:0] x;
    repeat (k) begin
      x = rand_byte();
      add_req(CMD_PUSH_HEAD, x);
      add_req(CMD_PUSH_TAIL, x);
    end
  endtask

  task automatic add_mirror_seq();
    int k;
    int m;
    if ($urandom_range(1)) add_drain(0);
    k = $urandom_range(1, 6);
    if (2 * k > DEPTH - gen_held) k = (DEPTH - gen_held) / 2;
    if (k == 0) begin
      add_drain($urandom_range(1));
      return;
    end
    add_mirror_pairs(k);
    add_req(CMD_CHECK, rand_byte());
    if ($urandom_range(1) && gen_held < DEPTH) begin
      // break the symmetry on one side, check, then undo it
      if ($urandom_range(1)) begin
        add_req(CMD_PUSH_TAIL, rand_byte());
        add_req(CMD_CHECK, rand_byte());
        add_req(CMD_POP_TAIL, rand_byte());
      end else begin
        add_req(CMD_PUSH_HEAD, rand_byte());
        add_req(CMD_CHECK, rand_byte());
        add_req(CMD_POP_HEAD, rand_byte());
      end
    end
    m = $urandom_range(0, gen_held / 2);
    repeat (m) begin
      add_req(CMD_POP_HEAD, rand_byte());
      add_req(CMD_POP_TAIL, rand_byte());
    end
    add_req(CMD_CHECK, rand_byte());
  endtask

  task automatic add_lopsided_seq();
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(3) != 0)
        add_req($urandom_range(1) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL, rand_byte());
      else
        add_rand_pop();
    end
    add_req(CMD_CHECK, rand_byte());
  endtask

  task automatic add_fill(bit mirrored);
    if (mirrored) begin
      add_drain(0);
      add_mirror_pairs(DEPTH / 2);
    end else begin
      while (gen_held < DEPTH)
        add_req($urandom_range(1) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL, rand_byte());
    end
    add_req(CMD_CHECK, rand_byte());
    add_req(CMD_PUSH_HEAD, rand_byte());
    add_req(CMD_PUSH_TAIL, rand_byte());
    add_req(CMD_CHECK, rand_byte());
  endtask

  initial begin
    bit filled_a;
    bit filled_b;
    filled_a = 1'b0;
    filled_b = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_PUSH_HEAD;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;

    // directed corners
    add_req(CMD_POP_HEAD, 8'h00);
    add_req(CMD_POP_TAIL, 8'hff);
    add_req(CMD_CHECK, 8'h00);
    add_req(CMD_PUSH_HEAD, 8'h00);
    add_req(CMD_CHECK, 8'hff);
    add_req(CMD_POP_TAIL, 8'h00);
    add_req(CMD_PUSH_TAIL, 8'hff);
    add_req(CMD_PUSH_HEAD, 8'hff);
    add_req(CMD_CHECK, 8'h00);
    add_req(CMD_PUSH_TAIL, 8'h80);
    add_req(CMD_CHECK, 8'h00);
    add_req(CMD_SPARE_A, 8'h55);
    add_req(CMD_SPARE_B, 8'haa);
    add_req(CMD_SPARE_C, 8'hff);
    add_req(CMD_POP_HEAD, 8'h00);
    add_req(CMD_POP_TAIL, 8'h00);
    add_req(CMD_POP_HEAD, 8'h00);
    add_req(CMD_PUSH_TAIL, 8'h12);
    add_req(CMD_PUSH_TAIL, 8'h34);
    add_req(CMD_PUSH_TAIL, 8'h12);
    add_req(CMD_CHECK, 8'h00);
    add_req(CMD_POP_HEAD, 8'h00);
    add_req(CMD_POP_HEAD, 8'h00);
    add_req(CMD_POP_TAIL, 8'h00);

    while (n_items < ITEMS_TOTAL) begin
      if (!filled_a && n_items >= 100) begin
        add_fill(1'b1);
        filled_a = 1'b1;
      end else if (!filled_b && n_items >= 320) begin
        add_fill(1'b0);
        filled_b = 1'b1;
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: add_mirror_seq();
          5, 6:          add_drain($urandom_range(1, 2));
          7: begin
            repeat ($urandom_range(1, 4))
              add_req(CMD_W'($urandom_range(7)), rand_byte());
          end
          default:       add_lopsided_seq();
        endcase
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (req_accepted != n_items) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      err_cnt++;
    end

    $display("tb: %0d requests sent, %0d results compared, %0d errors", n_items,
             res_checked, err_cnt);
    $display("tb: %0d palindrome checks (%0d true), %0d full rejects, %0d empty pops",
             sym_checks, sym_true, full_rejects, empty_pops);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
